// ===== rtl/core/c2d_pkg.sv =====
`timescale 1ns / 1ps
package c2d_pkg;

	typedef enum logic [2:0] {
		MODE_FILL   = 3'd0,
		MODE_OUTL   = 3'd1,
		MODE_HLINE  = 3'd2,
		MODE_VLINE  = 3'd3,
		MODE_CIRC   = 3'd4,
		MODE_FCIRC  = 3'd5,
		MODE_DIFF   = 3'd6,
		MODE_READ   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		JOB_NONE = 2'd0,
		JOB_RECT = 2'd1,
		JOB_DIFF = 2'd2,
		JOB_READ = 2'd3
	} job_t;

	localparam int unsigned REG_WIDTH  = 0;
	localparam int unsigned REG_HEIGHT = 1;

	localparam logic [15:0] BLANK_PIXEL = 16'hffff;

	// one classified command, the back part walks the box x0..x1, y0..y1
	typedef struct packed {
		job_t        job;
		logic        ok;
		logic        circ;
		logic        filled;
		logic        outline;
		logic [8:0]  x0;
		logic [8:0]  x1;
		logic [8:0]  y0;
		logic [8:0]  y1;
		logic [8:0]  cx;
		logic [8:0]  cy;
		logic [12:0] rad;
		logic [15:0] color;
	} cmd_t;

endpackage

// ===== rtl/core/c2d_ram.sv =====
`timescale 1ns / 1ps
module c2d_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/c2d_front.sv =====
`timescale 1ns / 1ps
module c2d_front
	import c2d_pkg::*;
#(
	parameter int unsigned MAX_RADIUS = 511
) (
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [15:0] col,
	input  logic [15:0] row,
	input  logic [15:0] size_w,
	input  logic [15:0] size_h,
	input  logic [15:0] color,
	input  logic [8:0]  act_w,
	input  logic [8:0]  act_h,
	output logic        q_push,
	input  logic        q_full,
	output cmd_t        q_cmd
);

	logic        in_frame;
	logic [16:0] xe;
	logic [16:0] ye;
	logic [16:0] le;
	logic [8:0]  xl;
	logic [8:0]  yl;
	logic [8:0]  ylv;
	cmd_t        c;

	assign full   = q_full;
	assign q_push = push && !q_full;
	assign q_cmd  = c;

	assign in_frame = (col < {7'd0, act_w}) && (row < {7'd0, act_h});
	assign xe = {1'b0, col} + {1'b0, size_w};
	assign ye = {1'b0, row} + {1'b0, size_h};
	assign le = {1'b0, row} + {1'b0, size_w};
	assign xl = (xe > {8'd0, act_w}) ? act_w - 9'd1 : xe[8:0] - 9'd1;
	assign yl = (ye > {8'd0, act_h}) ? act_h - 9'd1 : ye[8:0] - 9'd1;
	assign ylv = (le > {8'd0, act_h}) ? act_h - 9'd1 : le[8:0] - 9'd1;

	always_comb begin
		c = '0;
		c.color = color;
		c.x0 = col[8:0];
		c.y0 = row[8:0];
		c.x1 = col[8:0];
		c.y1 = row[8:0];
		c.cx = col[8:0];
		c.cy = row[8:0];
		c.rad = size_w[12:0];
		unique case (mode_t'(mode))
			MODE_FILL, MODE_OUTL: begin
				c.ok = in_frame && (size_w != 16'd0) && (size_h != 16'd0);
				c.job = c.ok ? JOB_RECT : JOB_NONE;
				c.outline = (mode_t'(mode) == MODE_OUTL);
				c.x1 = xl;
				c.y1 = yl;
			end
			MODE_HLINE: begin
				c.ok = in_frame && (size_w != 16'd0);
				c.job = c.ok ? JOB_RECT : JOB_NONE;
				c.x1 = (xe > {8'd0, act_w}) ? act_w - 9'd1 : xe[8:0] - 9'd1;
			end
			MODE_VLINE: begin
				c.ok = in_frame && (size_w != 16'd0);
				c.job = c.ok ? JOB_RECT : JOB_NONE;
				c.y1 = ylv;
			end
			MODE_CIRC, MODE_FCIRC: begin
				c.ok = (col <= {7'd0, act_w}) && (row <= {7'd0, act_h})
					&& (size_w <= 16'(MAX_RADIUS));
				c.job = (c.ok && act_w != 9'd0 && act_h != 9'd0
					&& size_w != 16'd0) ? JOB_RECT : JOB_NONE;
				c.circ = 1'b1;
				c.filled = (mode_t'(mode) == MODE_FCIRC);
				c.x0 = '0;
				c.y0 = '0;
				c.x1 = act_w - 9'd1;
				c.y1 = act_h - 9'd1;
			end
			MODE_DIFF: begin
				c.ok = 1'b1;
				c.job = (act_w != 9'd0 && act_h != 9'd0) ? JOB_DIFF : JOB_NONE;
				c.x0 = '0;
				c.y0 = '0;
				c.x1 = act_w - 9'd1;
				c.y1 = act_h - 9'd1;
			end
			MODE_READ: begin
				c.ok = in_frame;
				c.job = in_frame ? JOB_READ : JOB_NONE;
			end
			default: c.job = JOB_NONE;
		endcase
	end

endmodule

// ===== rtl/core/c2d_fifo.sv =====
`timescale 1ns / 1ps
module c2d_fifo
	import c2d_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output cmd_t rdata,
	output logic empty
);

	cmd_t       mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// ===== rtl/core/c2d_back.sv =====
`timescale 1ns / 1ps
module c2d_back
	import c2d_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [8:0]  act_w,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic [15:0] read_color,
	output logic        read_dirty
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DRAW, ST_CALC, ST_DCHK, ST_DRD, ST_DWR,
		ST_RRD, ST_RWAIT, ST_OUT
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [8:0]  x_q;
	logic [8:0]  y_q;
	logic [AW:0] clr_q;
	logic        ok_q;
	logic [15:0] rc_q;
	logic        rd_q;
	logic        full_q;
	logic [19:0] dx2_q;
	logic [19:0] dy2_q;

	logic [AW-1:0] addr;
	logic [AW-1:0] paddr;
	logic [31:0]   a32;
	logic          pix_we;
	logic [15:0]   pix_wd;
	logic [15:0]   pix_rd;
	logic          prv_we;
	logic [15:0]   prv_rd;
	logic          drt_we;
	logic [0:0]    drt_wd;
	logic [0:0]    drt_rd;
	logic signed [9:0]  dx;
	logic signed [9:0]  dy;
	logic signed [24:0] e;
	logic signed [24:0] rs;
	logic          hit;
	logic          edge_x;
	logic          edge_y;
	logic          last_x;
	logic          last_y;

	assign a32   = {23'd0, x_q} + 32'(y_q) * {23'd0, act_w};
	assign paddr = a32[AW-1:0];
	assign addr  = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : paddr;

	assign dx = $signed({1'b0, x_q}) - $signed({1'b0, cmd_q.cx});
	assign dy = $signed({1'b0, y_q}) - $signed({1'b0, cmd_q.cy});
	assign rs = $signed({12'd0, cmd_q.rad});
	assign e  = $signed({5'd0, dx2_q}) + $signed({5'd0, dy2_q}) - rs * rs;
	assign hit = cmd_q.filled ? (e < rs) : ((e < rs) && (-e < rs));

	assign edge_x = (x_q == cmd_q.x0) || (x_q == cmd_q.x1);
	assign edge_y = (y_q == cmd_q.y0) || (y_q == cmd_q.y1);
	assign last_x = (x_q == cmd_q.x1);
	assign last_y = (y_q == cmd_q.y1);

	always_comb begin
		pix_we = 1'b0;
		pix_wd = cmd_q.color;
		prv_we = 1'b0;
		drt_we = 1'b0;
		drt_wd = 1'(pix_rd != prv_rd);
		unique case (state_q)
			ST_CLEAR: begin
				pix_we = 1'b1;
				pix_wd = BLANK_PIXEL;
				prv_we = 1'b1;
				drt_we = 1'b1;
				drt_wd = 1'b0;
			end
			ST_DRAW: pix_we = !cmd_q.circ && (!cmd_q.outline || edge_x || edge_y);
			ST_DCHK: pix_we = hit;
			ST_DWR: begin
				prv_we = 1'b1;
				drt_we = 1'b1;
			end
			default: ;
		endcase
	end

	c2d_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pix (
		.clk(clk), .we(pix_we), .waddr(addr), .wdata(pix_wd),
		.raddr(addr), .rdata(pix_rd)
	);
	c2d_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_prv (
		.clk(clk), .we(prv_we), .waddr(addr),
		.wdata((state_q == ST_CLEAR) ? 16'd0 : pix_rd),
		.raddr(addr), .rdata(prv_rd)
	);
	c2d_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_drt (
		.clk(clk), .we(drt_we), .waddr(addr), .wdata(drt_wd),
		.raddr(addr), .rdata(drt_rd)
	);

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign empty      = !full_q;
	assign accepted   = ok_q;
	assign read_color = rc_q;
	assign read_dirty = rd_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		dx2_q <= 20'(dx * dx);
		dy2_q <= 20'(dy * dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			full_q  <= 1'b0;
			ok_q    <= 1'b0;
			rc_q    <= '0;
			rd_q    <= 1'b0;
		end else begin
			if (full_q && pop && state_q != ST_OUT) begin
				full_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						x_q <= q_cmd.x0;
						y_q <= q_cmd.y0;
						unique case (q_cmd.job)
							JOB_RECT: state_q <= q_cmd.circ ? ST_CALC : ST_DRAW;
							JOB_DIFF: state_q <= ST_DRD;
							JOB_READ: state_q <= ST_RRD;
							default:  state_q <= ST_OUT;
						endcase
					end
				end
				ST_DRAW: begin
					x_q <= last_x ? cmd_q.x0 : x_q + 9'd1;
					if (last_x) begin
						y_q <= y_q + 9'd1;
						if (last_y) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_CALC: begin
					state_q <= ST_DCHK;
				end
				ST_DCHK: begin
					x_q <= last_x ? cmd_q.x0 : x_q + 9'd1;
					if (last_x) begin
						y_q <= y_q + 9'd1;
					end
					state_q <= (last_x && last_y) ? ST_OUT : ST_CALC;
				end
				ST_DRD: state_q <= ST_DWR;
				ST_DWR: begin
					x_q <= last_x ? cmd_q.x0 : x_q + 9'd1;
					if (last_x) begin
						y_q <= y_q + 9'd1;
					end
					state_q <= (last_x && last_y) ? ST_OUT : ST_DRD;
				end
				ST_RRD: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!full_q || pop) begin
						full_q  <= 1'b1;
						ok_q    <= cmd_q.ok;
						rc_q    <= (cmd_q.job == JOB_READ) ? pix_rd : 16'd0;
						rd_q    <= (cmd_q.job == JOB_READ) ? drt_rd[0] : 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/clipped_2d_draw_engine.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake         | payload
// command  | in        | push / full       | mode col row size_w size_h color
// result   | out       | pop / empty       | accepted read_color read_dirty
// config   | in        | cfg_valid / ready | cfg_index cfg_data
// a rectangle or line visits one pixel of its clipped box per cycle
// a circle squares the offsets in ST_CALC, then tests and writes in ST_DCHK, per frame pixel
// a diff reads each frame pixel in ST_DRD and writes it back in ST_DWR, a read passes
// ST_RRD and ST_RWAIT; after reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT ram entries runs before commands
// a two-entry queue sits between decode and the drawing sequencer
module clipped_2d_draw_engine
	import c2d_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned MAX_RADIUS = 511
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [15:0] col,
	input  logic [15:0] row,
	input  logic [15:0] size_w,
	input  logic [15:0] size_h,
	input  logic [15:0] color,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic [15:0] read_color,
	output logic        read_dirty,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] fw_q;
	logic [7:0] fh_q;
	logic [8:0] act_w;
	logic [8:0] act_h;
	logic       qw;
	logic       qf;
	logic       qe;
	logic       qr;
	cmd_t       qin;
	cmd_t       qout;

	assign cfg_ready = 1'b1;
	assign act_w = ({1'b0, fw_q} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, fw_q};
	assign act_h = ({1'b0, fh_q} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {1'b0, fh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 8'd128;
			fh_q <= 8'd128;
		end else if (cfg_valid) begin
			if (cfg_index == 1'(REG_WIDTH)) begin
				fw_q <= cfg_data;
			end else begin
				fh_q <= cfg_data;
			end
		end
	end

	c2d_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
		.push(push), .full(full), .mode(mode),
		.col(col), .row(row), .size_w(size_w), .size_h(size_h), .color(color),
		.act_w(act_w), .act_h(act_h), .q_push(qw), .q_full(qf), .q_cmd(qin)
	);

	c2d_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(qw), .wdata(qin), .full(qf),
		.rd(qr), .rdata(qout), .empty(qe)
	);

	c2d_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .act_w(act_w), .q_empty(qe), .q_cmd(qout),
		.q_pop(qr), .empty(empty), .pop(pop), .accepted(accepted),
		.read_color(read_color), .read_dirty(read_dirty)
	);

endmodule
